@@ rtl/ascii_length_frame_deframer_defines.svh @@
// Assertion macros shared by the deframer RTL.
`ifndef ASCII_LENGTH_FRAME_DEFRAMER_DEFINES_SVH
`define ASCII_LENGTH_FRAME_DEFRAMER_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, disabled during reset.
`define ALF_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ALF_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ALF_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define ALF_ASSERT_NXT(label, clk, rst, ante, cons, msg)

`endif

`endif

@@ rtl/alf_pkg.sv @@
`timescale 1ns / 1ps

package alf_pkg;

  // Number of ASCII decimal digits in the length field.
  localparam int LENGTH_DIGITS = 3;
  localparam int DCNT_W        = $clog2(LENGTH_DIGITS + 1);
  localparam int LEN_W         = 10;
  localparam int PROD_W        = LEN_W + 4;

  localparam logic [LEN_W-1:0] LEN_MAX    = '1;
  localparam logic [7:0]       START_BYTE = 8'h3A;
  localparam logic [7:0]       MARK_BYTE  = 8'h7E;
  localparam logic [7:0]       DIGIT_ZERO = 8'h30;
  localparam logic [7:0]       DIGIT_NINE = 8'h39;

  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_BADSTOP = 2'd2,
    KIND_LENERR  = 2'd3
  } kind_t;

  typedef enum logic [4:0] {
    PH_HUNT    = 5'b00001,
    PH_COLON   = 5'b00010,
    PH_DIGITS  = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_STOP    = 5'b10000
  } phase_t;

endpackage

@@ rtl/alf_byte_if.sv @@
`timescale 1ns / 1ps

interface alf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

@@ rtl/alf_result_if.sv @@
`timescale 1ns / 1ps

interface alf_result_if import alf_pkg::*;;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  kind_t      kind;

  modport source (output valid, output data_byte, output kind, input ready);
  modport sink (input valid, input data_byte, input kind, output ready);
endinterface

@@ rtl/ascii_length_frame_deframer.sv @@
`timescale 1ns / 1ps
`include "ascii_length_frame_deframer_defines.svh"

// Byte-stream deframer for frames of the form ':' '~' <LENGTH_DIGITS ASCII
// decimal digits> <payload> '~'. The phase, length and byte counters are
// updated in the cycle of the transfer and any result lands in the output
// register, so a new byte is taken in every cycle that the output register
// is empty or being drained. Payload
// bytes come out as kind 0 as they arrive; the stop position gives kind 1
// (good end) or kind 2 (bad stop byte); a non-digit or zero length gives
// kind 3. After any status report (kind 1 to 3) the deframer hunts for ':' from the next byte.
module ascii_length_frame_deframer import alf_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  alf_byte_if.sink     rx,
  alf_result_if.source res
);

  phase_t            phase, phase_next;
  logic [LEN_W-1:0]  length_accum, length_accum_next;
  logic [DCNT_W-1:0] digit_cnt, digit_cnt_next;
  logic [LEN_W-1:0]  bytes_left, bytes_left_next;
  logic              out_valid;
  logic [7:0]        out_data;
  kind_t             out_kind;

  logic              accept;
  logic              produce;
  logic [7:0]        prod_data;
  kind_t             prod_kind;
  logic              is_digit;
  logic [3:0]        digit_val;
  logic [PROD_W-1:0] acc_wide;
  logic [LEN_W-1:0]  acc_sat;
  logic [DCNT_W-1:0] digit_cnt_inc;

  assign rx.ready = !out_valid || res.ready;
  assign accept   = rx.valid && rx.ready;

  assign is_digit  = (rx.rx_byte >= DIGIT_ZERO) && (rx.rx_byte <= DIGIT_NINE);
  assign digit_val = 4'(rx.rx_byte - DIGIT_ZERO);
  // length * 10 as (length << 3) + (length << 1), then the new digit.
  assign acc_wide  = ({4'b0, length_accum} << 3) + ({4'b0, length_accum} << 1)
                   + {{(PROD_W-4){1'b0}}, digit_val};
  assign acc_sat   = (acc_wide > {4'b0, LEN_MAX}) ? LEN_MAX : acc_wide[LEN_W-1:0];
  assign digit_cnt_inc = digit_cnt + 1'b1;

  always_comb begin
    phase_next        = phase;
    length_accum_next = length_accum;
    digit_cnt_next    = digit_cnt;
    bytes_left_next   = bytes_left;
    produce           = 1'b0;
    prod_data         = '0;
    prod_kind         = KIND_DATA;
    case (phase)
      PH_COLON: begin
        if (rx.rx_byte == MARK_BYTE) begin
          phase_next        = PH_DIGITS;
          length_accum_next = '0;
          digit_cnt_next    = '0;
        end else if (rx.rx_byte != START_BYTE) begin
          phase_next = PH_HUNT;
        end
      end
      PH_DIGITS: begin
        if (!is_digit) begin
          phase_next        = PH_HUNT;
          length_accum_next = '0;
          digit_cnt_next    = '0;
          produce           = 1'b1;
          prod_kind         = KIND_LENERR;
        end else begin
          length_accum_next = acc_sat;
          digit_cnt_next    = digit_cnt_inc;
          if (digit_cnt_inc == DCNT_W'(LENGTH_DIGITS)) begin
            digit_cnt_next = '0;
            if (acc_sat == '0) begin
              phase_next = PH_HUNT;
              produce    = 1'b1;
              prod_kind  = KIND_LENERR;
            end else begin
              phase_next      = PH_PAYLOAD;
              bytes_left_next = acc_sat;
            end
          end
        end
      end
      PH_PAYLOAD: begin
        produce         = 1'b1;
        prod_data       = rx.rx_byte;
        prod_kind       = KIND_DATA;
        bytes_left_next = bytes_left - 1'b1;
        if (bytes_left == LEN_W'(1)) begin
          phase_next = PH_STOP;
        end
      end
      PH_STOP: begin
        phase_next = PH_HUNT;
        produce    = 1'b1;
        prod_kind  = (rx.rx_byte == MARK_BYTE) ? KIND_GOOD : KIND_BADSTOP;
      end
      default: begin
        phase_next = (rx.rx_byte == START_BYTE) ? PH_COLON : PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      length_accum <= '0;
      digit_cnt    <= '0;
      bytes_left   <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        phase        <= phase_next;
        length_accum <= length_accum_next;
        digit_cnt    <= digit_cnt_next;
        bytes_left   <= bytes_left_next;
        out_valid    <= produce;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && produce) begin
      out_data <= prod_data;
      out_kind <= prod_kind;
    end
  end

  assign res.valid     = out_valid;
  assign res.data_byte = out_data;
  assign res.kind      = out_kind;

  `ALF_ASSERT_IMP(a_status_zero_data, clk, rst,
    res.valid && (res.kind != KIND_DATA), res.data_byte == 8'h00,
    "status result carries nonzero data")
  `ALF_ASSERT_NXT(a_payload_emits, clk, rst,
    accept && (phase == PH_PAYLOAD), res.valid && (res.kind == KIND_DATA),
    "payload byte transfer did not produce a data result")
  `ALF_ASSERT_NXT(a_hunt_silent, clk, rst,
    accept && ((phase == PH_HUNT) || (phase == PH_COLON)), !res.valid,
    "result appeared while hunting for a frame start")
  `ALF_ASSERT_IMP(a_payload_count, clk, rst,
    phase == PH_PAYLOAD, bytes_left != '0,
    "payload phase with no bytes left")

endmodule

@@ tb/ascii_length_frame_deframer_tb.sv @@
`timescale 1ns / 1ps

module ascii_length_frame_deframer_tb;
  import alf_pkg::*;

  localparam int ITEMS        = 1300;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 10;

  // Hand-picked opening stream: a repeated start byte with extreme payload
  // values, a zero length, a non-digit just below '0', a payload byte equal
  // to the mark with a start byte in the stop position, and a start byte
  // followed by an unrelated byte.
  localparam logic [7:0] OPENING_STREAM [26] = '{
    START_BYTE, START_BYTE, MARK_BYTE, "0", "0", "2", 8'hFF, 8'h00, MARK_BYTE,
    START_BYTE, MARK_BYTE, "0", "0", "0",
    START_BYTE, MARK_BYTE, "/",
    START_BYTE, MARK_BYTE, "0", "0", "1", MARK_BYTE, START_BYTE,
    START_BYTE, "B"
  };

  class frame_scoreboard;
    typedef struct packed {
      logic [7:0] data;
      kind_t      kind;
    } result_t;

    result_t          expected_q[$];
    phase_t           phase;
    logic [LEN_W-1:0] length_accum;
    logic [LEN_W-1:0] bytes_left;
    int unsigned      digits_taken;
    int               errors;
    int               kind_seen[4];

    function new();
      phase        = PH_HUNT;
      length_accum = '0;
      bytes_left   = '0;
      digits_taken = 0;
      errors       = 0;
    endfunction

    function void queue_result(logic [7:0] data, kind_t kind);
      result_t r;
      r.data = data;
      r.kind = kind;
      expected_q.push_back(r);
    endfunction

    // Advances the deframer state by one received byte.
    function void note_byte(logic [7:0] b);
      int unsigned acc;
      case (phase)
        PH_COLON: begin
          if (b == MARK_BYTE) begin
            phase        = PH_DIGITS;
            length_accum = '0;
            digits_taken = 0;
          end else if (b != START_BYTE) begin
            phase = PH_HUNT;
          end
        end
        PH_DIGITS: begin
          if (b < DIGIT_ZERO || b > DIGIT_NINE) begin
            phase        = PH_HUNT;
            length_accum = '0;
            digits_taken = 0;
            queue_result(8'h00, KIND_LENERR);
          end else begin
            acc = length_accum * 10 + (b - DIGIT_ZERO);
            if (acc > LEN_MAX) acc = LEN_MAX;
            length_accum = acc[LEN_W-1:0];
            digits_taken++;
            if (digits_taken >= LENGTH_DIGITS) begin
              digits_taken = 0;
              if (length_accum == '0) begin
                phase = PH_HUNT;
                queue_result(8'h00, KIND_LENERR);
              end else begin
                bytes_left = length_accum;
                phase      = PH_PAYLOAD;
              end
            end
          end
        end
        PH_PAYLOAD: begin
          if (bytes_left != '0) bytes_left--;
          if (bytes_left == '0) phase = PH_STOP;
          queue_result(b, KIND_DATA);
        end
        PH_STOP: begin
          phase = PH_HUNT;
          queue_result(8'h00, (b == MARK_BYTE) ? KIND_GOOD : KIND_BADSTOP);
        end
        default: begin
          phase = (b == START_BYTE) ? PH_COLON : PH_HUNT;
        end
      endcase
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [7:0] data, kind_t kind);
      result_t exp;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result data %02h kind %0d", data, kind));
        return;
      end
      exp = expected_q.pop_front();
      if (kind !== exp.kind) begin
        report($sformatf("kind %0d, expected %0d", kind, exp.kind));
      end
      if (data !== exp.data) begin
        report($sformatf("data_byte %02h, expected %02h", data, exp.data));
      end
      kind_seen[exp.kind]++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  alf_byte_if   rx_if ();
  alf_result_if res_if ();

  frame_scoreboard sb = new();

  bit tx_fast;
  bit rx_fast;
  bit hold_req;
  int bytes_fed;

  ascii_length_frame_deframer i_dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_if),
    .res (res_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Called at a falling edge; returns at the falling edge after the transfer
  // with valid still high, so the caller lowers it when the stream pauses.
  task automatic send_byte(logic [7:0] b);
    int gap;
    if ($urandom_range(0, 29) == 0) tx_fast = !tx_fast;
    gap = tx_fast ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      rx_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    rx_if.valid   = 1'b1;
    rx_if.rx_byte = b;
    do @(posedge clk); while (!rx_if.ready);
    sb.note_byte(b);
    bytes_fed++;
    @(negedge clk);
  endtask

  task automatic send_noise(int n);
    repeat (n) begin
      send_byte(8'($urandom));
    end
  endtask

  task automatic send_frame(int unsigned len, logic [7:0] stop);
    send_byte(START_BYTE);
    send_byte(MARK_BYTE);
    send_byte(DIGIT_ZERO + 8'(len / 100));
    send_byte(DIGIT_ZERO + 8'((len / 10) % 10));
    send_byte(DIGIT_ZERO + 8'(len % 10));
    if (len == 0) return;
    repeat (len) send_byte(8'($urandom));
    send_byte(stop);
  endtask

  function automatic int unsigned draw_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 12);
    if (r < 92) return $urandom_range(13, 99);
    return $urandom_range(100, 300);
  endfunction

  function automatic logic [7:0] draw_stop();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return MARK_BYTE;
    if (r < 90) return START_BYTE;
    return 8'($urandom);
  endfunction

  // A header whose length field breaks off at a random digit position.
  task automatic send_bad_length();
    logic [7:0] b;
    int         k;
    k = $urandom_range(0, LENGTH_DIGITS - 1);
    send_byte(START_BYTE);
    send_byte(MARK_BYTE);
    repeat (k) send_byte(DIGIT_ZERO + 8'($urandom_range(0, 9)));
    do b = 8'($urandom); while (b >= DIGIT_ZERO && b <= DIGIT_NINE);
    send_byte(b);
  endtask

  initial begin
    int gap;
    wait (!rst);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 29) == 0) rx_fast = !rx_fast;
      gap = rx_fast ? 0 : $urandom_range(0, 15);
      if (hold_req) begin
        gap      = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (gap > 0) begin
        res_if.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      res_if.ready = 1'b1;
      do @(posedge clk); while (!res_if.valid);
      sb.check_result(res_if.data_byte, res_if.kind);
      @(negedge clk);
    end
  end

  initial begin
    int idle;
    idle = 0;
    wait (!rst);
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    bit held;
    bit paused;
    int pick;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = 8'h00;
    res_if.ready  = 1'b0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    foreach (OPENING_STREAM[i]) send_byte(OPENING_STREAM[i]);

    // The longest length the field can carry, sent once.
    send_frame(999, MARK_BYTE);

    while (bytes_fed < ITEMS || !held || !paused) begin
      if (!held && bytes_fed >= 1100) begin
        // The receiver stalls while the sender offers a long frame at full rate and back-pressure holds it.
        held     = 1'b1;
        tx_fast  = 1'b1;
        hold_req = 1'b1;
        send_frame(40, MARK_BYTE);
      end
      if (!paused && bytes_fed >= 1200) begin
        paused      = 1'b1;
        rx_if.valid = 1'b0;
        while (sb.expected_q.size() != 0) @(negedge clk);
      end
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        send_noise($urandom_range(1, 4));
      end else if (pick < 17) begin
        send_bad_length();
      end else if (pick < 21) begin
        send_frame(0, MARK_BYTE);
      end else if (pick < 25) begin
        repeat ($urandom_range(1, 3)) send_byte(START_BYTE);
        if ($urandom_range(0, 1) == 0) begin
          send_byte(8'($urandom));
        end else begin
          send_frame(draw_len(), draw_stop());
        end
      end else begin
        send_frame(draw_len(), draw_stop());
      end
    end
    rx_if.valid = 1'b0;

    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Fed %0d bytes; checked %0d payload bytes and %0d good ends,",
             bytes_fed, sb.kind_seen[KIND_DATA], sb.kind_seen[KIND_GOOD]);
    $display("%0d bad stop bytes and %0d length errors.",
             sb.kind_seen[KIND_BADSTOP], sb.kind_seen[KIND_LENERR]);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/alf_pkg.sv
rtl/alf_byte_if.sv
rtl/alf_result_if.sv
rtl/ascii_length_frame_deframer.sv
tb/ascii_length_frame_deframer_tb.sv
